### rtl/tpa_pkg.sv
// shared types and constants of the triangle primitive assembler
`default_nettype none
package tpa_pkg;

  localparam int unsigned FieldBits = 32;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgDataBits = 2;

  localparam logic [CfgIdxBits-1:0] CfgTopology = 1'd0;
  localparam logic [CfgIdxBits-1:0] CfgUseIndex = 1'd1;

  typedef enum logic [1:0] {
    TopoList  = 2'd0,
    TopoStrip = 2'd1,
    TopoFan   = 2'd2
  } topo_e;

  typedef struct packed {
    topo_e topology;
    logic  use_index;
  } cfg_t;

  typedef struct packed {
    logic [FieldBits-1:0] vertex_index;
    logic                 last_vertex;
  } vtx_t;

  typedef struct packed {
    logic [FieldBits-1:0] corner_a;
    logic [FieldBits-1:0] corner_b;
    logic [FieldBits-1:0] corner_c;
    logic [FieldBits-1:0] triangle_number;
    logic                 triangle_valid;
    logic                 end_of_primitive;
  } res_t;

endpackage
`default_nettype wire

### rtl/tpa_vertex_if.sv
// vertex channel: valid, ready and one index item
`default_nettype none
interface tpa_vertex_if;
  logic                           valid;
  logic                           ready;
  logic [tpa_pkg::FieldBits-1:0]  vertex_index;
  logic                           last_vertex;

  modport source (output valid, output vertex_index, output last_vertex, input ready);
  modport sink (input valid, input vertex_index, input last_vertex, output ready);
endinterface
`default_nettype wire

### rtl/tpa_tri_if.sv
// triangle channel: valid, ready and one triangle result
`default_nettype none
interface tpa_tri_if;
  logic                           valid;
  logic                           ready;
  logic [tpa_pkg::FieldBits-1:0]  corner_a;
  logic [tpa_pkg::FieldBits-1:0]  corner_b;
  logic [tpa_pkg::FieldBits-1:0]  corner_c;
  logic [tpa_pkg::FieldBits-1:0]  triangle_number;
  logic                           triangle_valid;
  logic                           end_of_primitive;

  modport source (
    output valid, output corner_a, output corner_b, output corner_c,
    output triangle_number, output triangle_valid, output end_of_primitive,
    input ready
  );
  modport sink (
    input valid, input corner_a, input corner_b, input corner_c,
    input triangle_number, input triangle_valid, input end_of_primitive,
    output ready
  );
endinterface
`default_nettype wire

### rtl/tpa_in_stage.sv
// input register stage for incoming vertex transactions
`default_nettype none
module tpa_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tpa_vertex_if.sink      vtx_i,
  input  wire logic       advance_i,
  output tpa_pkg::vtx_t   item_o,
  output logic            item_valid_o
);

  logic          valid_q;
  logic          valid_d;
  tpa_pkg::vtx_t item_q;
  logic          take;

  assign vtx_i.ready = !valid_q || advance_i;
  assign take        = vtx_i.valid && vtx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.vertex_index <= vtx_i.vertex_index;
      item_q.last_vertex  <= vtx_i.last_vertex;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule
`default_nettype wire

### rtl/tpa_core.sv
// assembly state, triangle forming logic and result register
`default_nettype none
module tpa_core #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tpa_pkg::cfg_t cfg_i,
  input  wire tpa_pkg::vtx_t item_i,
  input  wire logic          item_valid_i,
  output logic               advance_o,
  tpa_tri_if.source          tri_o
);

  localparam int unsigned FB = tpa_pkg::FieldBits;

  logic [INDEX_BITS-1:0] anchor_q, anchor_d;
  logic [INDEX_BITS-1:0] older_q, older_d;
  logic [INDEX_BITS-1:0] prev_q, prev_d;
  logic [FB-1:0]         seen_q, seen_d;
  logic [FB-1:0]         emitted_q, emitted_d;
  // vertices_seen - 3*triangles_emitted and vertices_seen - triangles_emitted
  logic [FB-1:0]         phase_q, phase_d;
  logic [FB-1:0]         fill_q, fill_d;

  logic                  res_valid_q, res_valid_d;
  tpa_pkg::res_t         res_q, res_d;

  logic [INDEX_BITS-1:0] v;
  logic                  emit;
  logic                  produce;
  logic                  fill_ge2;
  logic [INDEX_BITS-1:0] ca, cb, cc;

  always_comb begin
    v        = cfg_i.use_index ? item_i.vertex_index[INDEX_BITS-1:0]
                               : seen_q[INDEX_BITS-1:0];
    fill_ge2 = |fill_q[FB-1:1];
    emit     = 1'b0;
    ca       = '0;
    cb       = '0;
    cc       = '0;
    anchor_d = anchor_q;
    older_d  = older_q;
    prev_d   = prev_q;

    case (cfg_i.topology)
      tpa_pkg::TopoStrip: begin
        emit    = fill_ge2;
        ca      = older_q;
        cb      = emitted_q[0] ? v : prev_q;
        cc      = emitted_q[0] ? prev_q : v;
        older_d = prev_q;
        prev_d  = v;
      end
      tpa_pkg::TopoFan: begin
        emit    = fill_ge2;
        ca      = anchor_q;
        cb      = prev_q;
        cc      = v;
        if (fill_q == '0) begin
          anchor_d = v;
        end
        older_d = prev_q;
        prev_d  = v;
      end
      default: begin
        ca = older_q;
        cb = prev_q;
        cc = v;
        if (phase_q == '0) begin
          older_d = v;
        end else if (phase_q == FB'(1)) begin
          prev_d = v;
        end else begin
          emit = 1'b1;
        end
      end
    endcase

    produce   = emit || item_i.last_vertex;
    advance_o = item_valid_i && (!res_valid_q || tri_o.ready || !produce);

    seen_d    = seen_q + FB'(1);
    emitted_d = emit ? emitted_q + FB'(1) : emitted_q;
    phase_d   = emit ? phase_q - FB'(2) : phase_q + FB'(1);
    fill_d    = emit ? fill_q : fill_q + FB'(1);

    if (item_i.last_vertex) begin
      anchor_d  = '0;
      older_d   = '0;
      prev_d    = '0;
      seen_d    = '0;
      emitted_d = '0;
      phase_d   = '0;
      fill_d    = '0;
    end

    res_d.corner_a         = emit ? FB'(ca) : '0;
    res_d.corner_b         = emit ? FB'(cb) : '0;
    res_d.corner_c         = emit ? FB'(cc) : '0;
    res_d.triangle_number  = emit ? emitted_q : '0;
    res_d.triangle_valid   = emit;
    res_d.end_of_primitive = item_i.last_vertex;

    res_valid_d = res_valid_q;
    if (advance_o && produce) begin
      res_valid_d = 1'b1;
    end else if (tri_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q    <= '0;
      older_q     <= '0;
      prev_q      <= '0;
      seen_q      <= '0;
      emitted_q   <= '0;
      phase_q     <= '0;
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (advance_o) begin
        anchor_q  <= anchor_d;
        older_q   <= older_d;
        prev_q    <= prev_d;
        seen_q    <= seen_d;
        emitted_q <= emitted_d;
        phase_q   <= phase_d;
        fill_q    <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && produce) begin
      res_q <= res_d;
    end
  end

  assign tri_o.valid            = res_valid_q;
  assign tri_o.corner_a         = res_q.corner_a;
  assign tri_o.corner_b         = res_q.corner_b;
  assign tri_o.corner_c         = res_q.corner_c;
  assign tri_o.triangle_number  = res_q.triangle_number;
  assign tri_o.triangle_valid   = res_q.triangle_valid;
  assign tri_o.end_of_primitive = res_q.end_of_primitive;

endmodule
`default_nettype wire

### rtl/triangle_primitive_assembler.sv
// top level of the triangle primitive assembler
//
//   port        dir  handshake       carries
//   vtx_i       in   valid/ready     vertex_index, last_vertex
//   tri_o       out  valid/ready     corners a b c, triangle_number, flags
//   cfg_*_i     in   write enable    topology_mode (0), use_index_stream (1)
//
// one vertex transaction per cycle while a stalled result does not hold the core; the vertex sits in
// the input register and its result is loaded into the result register when the core advances
// reset clears all assembly state and the configuration (list, indexed)
// a stalled result holds the core only when the waiting vertex also yields a result
`default_nettype none
module triangle_primitive_assembler #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  tpa_vertex_if.sink                             vtx_i,
  tpa_tri_if.source                              tri_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [tpa_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  wire logic [tpa_pkg::CfgDataBits-1:0]   cfg_wdata_i
);

  tpa_pkg::cfg_t cfg_q;
  tpa_pkg::vtx_t item;
  logic          item_valid;
  logic          advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.topology  <= tpa_pkg::TopoList;
      cfg_q.use_index <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpa_pkg::CfgTopology: cfg_q.topology  <= tpa_pkg::topo_e'(cfg_wdata_i);
        tpa_pkg::CfgUseIndex: cfg_q.use_index <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  tpa_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vtx_i        (vtx_i),
    .advance_i    (advance),
    .item_o       (item),
    .item_valid_o (item_valid)
  );

  tpa_core #(
    .INDEX_BITS (INDEX_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .advance_o    (advance),
    .tri_o        (tri_o)
  );

endmodule
`default_nettype wire

### tb/sv/tb.sv
// testbench of the triangle primitive assembler: directed and random index streams vs a predictor
`timescale 1ns / 100ps
module tb;

  localparam int unsigned IndexBits = 32;
  localparam logic [tpa_pkg::FieldBits-1:0] IndexMask =
    (IndexBits >= 32) ? '1 : ((32'd1 << IndexBits) - 32'd1);
  localparam int unsigned ResetCycles = 5;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned WatchdogLimit = 200;
  localparam int unsigned TotalVertices = 1675;

  localparam logic [tpa_pkg::CfgDataBits-1:0] TopoUnused = 2'd3;
  localparam logic [tpa_pkg::CfgDataBits-1:0] UseCount = 2'd0;
  localparam logic [tpa_pkg::CfgDataBits-1:0] UseIndexStream = 2'd1;

  class triangle_scoreboard;
    logic [1:0]                    topology;
    bit                            use_index;
    logic [tpa_pkg::FieldBits-1:0] anchor;
    logic [tpa_pkg::FieldBits-1:0] older;
    logic [tpa_pkg::FieldBits-1:0] prev;
    logic [tpa_pkg::FieldBits-1:0] seen;
    logic [tpa_pkg::FieldBits-1:0] emitted;
    tpa_pkg::res_t                 triangles_q[$];
    int unsigned                   errors;

    function new();
      topology = tpa_pkg::TopoList;
      use_index = 1'b1;
      errors = 0;
      clear_assembly();
    endfunction

    function void clear_assembly();
      anchor = '0;
      older = '0;
      prev = '0;
      seen = '0;
      emitted = '0;
    endfunction

    function void set_register(logic [tpa_pkg::CfgIdxBits-1:0] idx,
                               logic [tpa_pkg::CfgDataBits-1:0] data);
      if (idx == tpa_pkg::CfgTopology) begin
        topology = data;
      end else begin
        use_index = data[0];
      end
    endfunction

    function int unsigned pending();
      return triangles_q.size();
    endfunction

    // works out the triangle, if any, that one accepted vertex transaction yields
    function void note_vertex(tpa_pkg::vtx_t item);
      logic [tpa_pkg::FieldBits-1:0] v;
      logic [tpa_pkg::FieldBits-1:0] fill;
      logic [tpa_pkg::FieldBits-1:0] phase;
      bit                            emit;
      tpa_pkg::res_t                 r;
      emit = 1'b0;
      r = '0;
      v = use_index ? (item.vertex_index & IndexMask) : (seen & IndexMask);
      if (topology == tpa_pkg::TopoStrip || topology == tpa_pkg::TopoFan) begin
        fill = seen - emitted;
        if (topology == tpa_pkg::TopoFan && fill == '0) begin
          anchor = v;
        end
        if (fill >= 2) begin
          emit = 1'b1;
          r.triangle_number = emitted;
          if (topology == tpa_pkg::TopoFan) begin
            r.corner_a = anchor;
            r.corner_b = prev;
            r.corner_c = v;
          end else if (emitted[0]) begin
            r.corner_a = older;
            r.corner_b = v;
            r.corner_c = prev;
          end else begin
            r.corner_a = older;
            r.corner_b = prev;
            r.corner_c = v;
          end
        end
        older = prev;
        prev = v;
      end else begin
        // list, and the unused code behaves as a list
        phase = seen - emitted * 32'd3;
        if (phase == 0) begin
          older = v;
        end else if (phase == 1) begin
          prev = v;
        end else begin
          emit = 1'b1;
          r.triangle_number = emitted;
          r.corner_a = older;
          r.corner_b = prev;
          r.corner_c = v;
        end
      end
      seen = seen + 1;
      if (emit) begin
        emitted = emitted + 1;
      end
      if (emit || item.last_vertex) begin
        r.triangle_valid = emit;
        r.end_of_primitive = item.last_vertex;
        triangles_q.insert(triangles_q.size(), r);
      end
      if (item.last_vertex) begin
        clear_assembly();
      end
    endfunction

    function void compare_field(string name, logic [tpa_pkg::FieldBits-1:0] want,
                                logic [tpa_pkg::FieldBits-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_triangle(tpa_pkg::res_t got);
      tpa_pkg::res_t want;
      if (triangles_q.size() == 0) begin
        $error("unexpected triangle transaction: %p", got);
        errors++;
        return;
      end
      want = triangles_q.pop_front();
      compare_field("corner_a", want.corner_a, got.corner_a);
      compare_field("corner_b", want.corner_b, got.corner_b);
      compare_field("corner_c", want.corner_c, got.corner_c);
      compare_field("triangle_number", want.triangle_number, got.triangle_number);
      compare_field("triangle_valid", tpa_pkg::FieldBits'(want.triangle_valid),
                    tpa_pkg::FieldBits'(got.triangle_valid));
      compare_field("end_of_primitive", tpa_pkg::FieldBits'(want.end_of_primitive),
                    tpa_pkg::FieldBits'(got.end_of_primitive));
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [tpa_pkg::CfgIdxBits-1:0]  cfg_idx_i;
  logic [tpa_pkg::CfgDataBits-1:0] cfg_wdata_i;

  tpa_vertex_if vtx_ch();
  tpa_tri_if    tri_ch();

  triangle_scoreboard sb = new();
  bit                 stall_free;
  int unsigned        vertices_sent;
  int unsigned        idle_cycles = 0;

  triangle_primitive_assembler #(
    .INDEX_BITS (IndexBits)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx_i       (vtx_ch),
    .tri_o       (tri_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [tpa_pkg::FieldBits-1:0] random_index();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vertex(logic [tpa_pkg::FieldBits-1:0] idx, bit last);
    int unsigned   gap;
    tpa_pkg::vtx_t item;
    gap = stall_free ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      vtx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    vtx_ch.valid <= 1'b1;
    vtx_ch.vertex_index <= idx;
    vtx_ch.last_vertex <= last;
    @(posedge clk_i);
    while (!vtx_ch.ready) @(posedge clk_i);
    item.vertex_index = idx;
    item.last_vertex = last;
    sb.note_vertex(item);
    vertices_sent++;
  endtask

  // hold off the sender until every triangle has come out and the pipeline is empty
  task automatic drain();
    vtx_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [tpa_pkg::CfgIdxBits-1:0] idx,
                           logic [tpa_pkg::CfgDataBits-1:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(idx, data);
  endtask

  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = stall_free ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        tri_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      tri_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!tri_ch.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    tpa_pkg::res_t got;
    if (rst_ni && tri_ch.valid && tri_ch.ready) begin
      got.corner_a = tri_ch.corner_a;
      got.corner_b = tri_ch.corner_b;
      got.corner_c = tri_ch.corner_c;
      got.triangle_number = tri_ch.triangle_number;
      got.triangle_valid = tri_ch.triangle_valid;
      got.end_of_primitive = tri_ch.end_of_primitive;
      sb.check_triangle(got);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles == WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else if ((vtx_ch.valid && vtx_ch.ready) || (tri_ch.valid && tri_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned length;
    bit          closed;
    int unsigned k;
    stall_free = 1'b0;
    vertices_sent = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= tpa_pkg::CfgTopology;
    cfg_wdata_i <= '0;
    vtx_ch.valid <= 1'b0;
    vtx_ch.vertex_index <= '0;
    vtx_ch.last_vertex <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // list after reset, extremes of the index
    send_vertex('1, 1'b0);
    send_vertex('0, 1'b0);
    send_vertex(32'h8000_0001, 1'b1);
    // two leftover list vertices: end marker only
    send_vertex(32'd5, 1'b0);
    send_vertex(32'd6, 1'b1);

    // strip with swapped odd triangles, then a strip too short
    write_cfg(tpa_pkg::CfgTopology, tpa_pkg::TopoStrip);
    for (k = 1; k <= 5; k++) send_vertex(k, k == 5);
    send_vertex(32'hAAAA_AAAA, 1'b1);

    write_cfg(tpa_pkg::CfgTopology, tpa_pkg::TopoFan);
    for (k = 10; k <= 13; k++) send_vertex(k, k == 13);

    // running count in place of the index
    write_cfg(tpa_pkg::CfgUseIndex, UseCount);
    for (k = 0; k < 3; k++) send_vertex($urandom, k == 2);
    write_cfg(tpa_pkg::CfgTopology, TopoUnused);
    for (k = 0; k < 4; k++) send_vertex($urandom, k == 3);

    // topology changed in the middle of a primitive
    write_cfg(tpa_pkg::CfgUseIndex, UseIndexStream);
    write_cfg(tpa_pkg::CfgTopology, tpa_pkg::TopoList);
    send_vertex(32'h5555_5555, 1'b0);
    send_vertex(32'hFFFF_0000, 1'b0);
    write_cfg(tpa_pkg::CfgTopology, tpa_pkg::TopoStrip);
    send_vertex(32'h0000_FFFF, 1'b1);

    while (vertices_sent < TotalVertices) begin
      stall_free = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 5))
        0: write_cfg(tpa_pkg::CfgTopology, tpa_pkg::CfgDataBits'($urandom_range(0, 3)));
        1: write_cfg(tpa_pkg::CfgUseIndex, tpa_pkg::CfgDataBits'($urandom_range(0, 1)));
        2: drain();
        default: ;
      endcase
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      closed = ($urandom_range(0, 7) != 0);
      for (k = 1; k <= length; k++) send_vertex(random_index(), closed && k == length);
    end

    stall_free = 1'b0;
    drain();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/tpa_pkg.sv
rtl/tpa_vertex_if.sv
rtl/tpa_tri_if.sv
rtl/tpa_in_stage.sv
rtl/tpa_core.sv
rtl/triangle_primitive_assembler.sv
tb/sv/tb.sv
